// File: rtl/bioimpedance_iq_to_impedance_macros.svh
// Assertion macros shared by the I/Q impedance block
`ifndef BIOIMPEDANCE_IQ_TO_IMPEDANCE_MACROS_SVH
`define BIOIMPEDANCE_IQ_TO_IMPEDANCE_MACROS_SVH
`ifndef SYNTHESIS
// condition that holds at every clock edge
`define BIQ_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
// implication within the same cycle
`define BIQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication into the next cycle
`define BIQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BIQ_ASSERT_ALWAYS(lbl, cond)
`define BIQ_ASSERT_IMPL(lbl, ante, cons)
`define BIQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/biq_pkg.sv
// Shared types and constants of the I/Q to impedance block
`timescale 1ns / 1ps
`default_nettype none
package biq_pkg;
	localparam int ADC_BITS    = 20;
	localparam int WORD_W      = 24;
	localparam int TAG_W       = 4;
	localparam int MAG_W       = 22;
	localparam int SQ_IN_W     = 2 * MAG_W;
	localparam int SQ_REM_W    = MAG_W + 2;
	localparam int CUR_W       = 16;
	localparam int LEAK_W      = 24;
	localparam int ISO_W       = 16;
	localparam int Z_W         = 32;
	localparam int SCALE_W     = 32;
	localparam int PROD1_W     = MAG_W + SCALE_W;
	localparam int SCALE_SHIFT = 18;
	localparam int N1_W        = PROD1_W - SCALE_SHIFT;
	localparam int PROD2_W     = Z_W + LEAK_W;
	localparam int N2_W        = PROD2_W + 4;
	localparam int DEN_W       = LEAK_W + 4;
	localparam int Q2_W        = 34;
	localparam int BODY_W      = 33;

	localparam logic [TAG_W-1:0]   TAG_I        = 4'h1;
	localparam logic [TAG_W-1:0]   TAG_Q        = 4'h2;
	localparam logic [WORD_W-1:0]  WORD_INVALID = 24'hFFFFFF;
	localparam logic [WORD_W-1:0]  WORD_MARKER  = 24'hFFFFFE;
	localparam logic [SCALE_W-1:0] SCALE_NUM    = 32'd3140000000;
	localparam logic [Z_W-1:0]     Z_SAT        = 32'hFFFFFFFF;

	localparam logic [CUR_W-1:0]  CUR_RST  = 16'd905;
	localparam logic [LEAK_W-1:0] LEAK_RST = 24'd10000000;
	localparam logic [ISO_W-1:0]  ISO_RST  = 16'd5428;

	localparam logic [1:0] CFG_DRIVE = 2'd0;
	localparam logic [1:0] CFG_LEAK  = 2'd1;
	localparam logic [1:0] CFG_ISO   = 2'd2;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_INVALID = 2'd1,
		ST_MARKER  = 2'd2,
		ST_TAG_ERR = 2'd3
	} status_t;

	// per-item data that rides along the arithmetic
	typedef struct packed {
		status_t                    status;
		logic signed [ADC_BITS-1:0] in_phase;
		logic signed [ADC_BITS-1:0] quadrature;
		logic [MAG_W-1:0]           mag;
	} side_t;
endpackage
`default_nettype wire

// File: rtl/biq_isqrt.sv
// Pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module biq_isqrt import biq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [SQ_IN_W-1:0] in_x,
	input  side_t              in_side,
	output logic               out_valid,
	output logic [MAG_W-1:0]   out_root,
	output side_t              out_side
);
	logic                v_s    [MAG_W];
	logic [MAG_W-1:0]    root_s [MAG_W];
	logic [SQ_REM_W-1:0] rem_s  [MAG_W];
	logic [SQ_IN_W-1:0]  x_s    [MAG_W];
	side_t               side_s [MAG_W];

	for (genvar g = 0; g < MAG_W; g++) begin : g_st
		logic                pv;
		logic [MAG_W-1:0]    proot;
		logic [SQ_REM_W-1:0] prem;
		logic [SQ_IN_W-1:0]  px;
		side_t               pside;
		logic [SQ_REM_W+1:0] cur;
		logic [SQ_REM_W+1:0] trial;
		logic                take;

		if (g == 0) begin : g_first
			assign pv    = in_valid;
			assign proot = '0;
			assign prem  = '0;
			assign px    = in_x;
			assign pside = in_side;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign proot = root_s[g-1];
			assign prem  = rem_s[g-1];
			assign px    = x_s[g-1];
			assign pside = side_s[g-1];
		end

		// bring in two radicand bits, try root*4+1
		always_comb begin
			cur   = {prem, px[SQ_IN_W-1 -: 2]};
			trial = {2'b00, proot, 2'b01};
			take  = (cur >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[g] <= {proot[MAG_W-2:0], take};
				rem_s[g]  <= take ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
				x_s[g]    <= {px[SQ_IN_W-3:0], 2'b00};
				side_s[g] <= pside;
			end
		end
	end

	assign out_valid = v_s[MAG_W-1];
	assign out_root  = root_s[MAG_W-1];
	assign out_side  = side_s[MAG_W-1];
endmodule
`default_nettype wire

// File: rtl/bioimpedance_iq_to_impedance.sv
// Top level: I/Q sample pair to measured and body impedance
//
// Input stream s_*: one item per I/Q word pair, tdata = {word_b, word_a}.
// Output stream m_*: one result item per input item, in order; tuser
// carries the status, tdata the numbers (zero unless status is valid).
// Configuration port cfg_*: a write with cfg_we high sets drive current
// (index 0), leakage resistance (1) or isolation resistance (2); write
// only while no item is in flight.
// From accepted input item to output tvalid the path is: three
// front stages, a 22-stage square root, a scaling multiply, a 36-stage
// divider by the drive current, three stages of saturation and leakage
// set-up, a 34-stage leakage divider and the output register.
// Throughput is one item per cycle. The pipeline advances as a whole: it
// moves whenever the output register is empty or being taken, so while
// m_tready is low with a result waiting, s_tready drops and every stage
// holds its item. Reset clears all valid bits and loads the registers
// with 905 nA, 10 Mohm and 5428 ohm.
`timescale 1ns / 1ps
`default_nettype none
`include "bioimpedance_iq_to_impedance_macros.svh"
module bioimpedance_iq_to_impedance import biq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [47:0]   s_tdata,  // word_a [23:0], word_b [47:24]
	output logic          m_tvalid,
	input  logic          m_tready,
	// in_phase [19:0], quadrature [39:20], magnitude_q2 [61:40],
	// impedance_q4 [93:62], body_impedance_q4 [126:94], overflow [127]
	output logic [127:0]  m_tdata,
	output logic [1:0]    m_tuser,  // status [1:0]
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [23:0]   cfg_data
);
	logic              en;
	logic [CUR_W-1:0]  drive_q;
	logic [LEAK_W-1:0] leak_q;
	logic [ISO_W-1:0]  iso_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q <= CUR_RST;
			leak_q  <= LEAK_RST;
			iso_q   <= ISO_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DRIVE: drive_q <= cfg_data[CUR_W-1:0];
				CFG_LEAK:  leak_q  <= cfg_data[LEAK_W-1:0];
				CFG_ISO:   iso_q   <= cfg_data[ISO_W-1:0];
				default:   ;
			endcase
		end
	end

	// output register
	logic              out_v_q;
	status_t           out_status_q;
	logic [127:0]      out_data_q;

	assign en       = !out_v_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// stage 1: classify the word pair and pick I and Q
	logic [WORD_W-1:0]   word_a, word_b;
	logic [WORD_W-1:0]   iw, qw;
	side_t               side_d;
	logic [ADC_BITS-1:0] ai_d, aq_d;

	always_comb begin
		word_a = s_tdata[WORD_W-1:0];
		word_b = s_tdata[2*WORD_W-1:WORD_W];
		iw     = '0;
		qw     = '0;
		side_d = '0;
		priority if (word_a[WORD_W-1 -: TAG_W] == TAG_I && word_b[WORD_W-1 -: TAG_W] == TAG_Q) begin
			iw            = word_a;
			qw            = word_b;
			side_d.status = ST_VALID;
		end else if (word_a[WORD_W-1 -: TAG_W] == TAG_Q
				&& word_b[WORD_W-1 -: TAG_W] == TAG_I) begin
			iw            = word_b;
			qw            = word_a;
			side_d.status = ST_VALID;
		end else if (word_a == WORD_INVALID && word_b == WORD_INVALID) begin
			side_d.status = ST_INVALID;
		end else if (word_a == WORD_MARKER && word_b == WORD_INVALID) begin
			side_d.status = ST_MARKER;
		end else begin
			side_d.status = ST_TAG_ERR;
		end
		side_d.in_phase   = iw[ADC_BITS-1:0];
		side_d.quadrature = qw[ADC_BITS-1:0];
		ai_d = side_d.in_phase[ADC_BITS-1] ? ADC_BITS'(-side_d.in_phase)
			: side_d.in_phase;
		aq_d = side_d.quadrature[ADC_BITS-1] ? ADC_BITS'(-side_d.quadrature)
			: side_d.quadrature;
	end

	logic                v_s1, v_s2, v_s3;
	side_t               side_s1, side_s2, side_s3;
	logic [ADC_BITS-1:0] ai_s1, aq_s1;
	logic [2*ADC_BITS-1:0] isq_s2, qsq_s2;
	logic [SQ_IN_W-1:0]  x_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stages 1 to 3: magnitudes, squares, 16*(I^2+Q^2)
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_d;
			ai_s1   <= ai_d;
			aq_s1   <= aq_d;
			side_s2 <= side_s1;
			isq_s2  <= (2*ADC_BITS)'(ai_s1) * (2*ADC_BITS)'(ai_s1);
			qsq_s2  <= (2*ADC_BITS)'(aq_s1) * (2*ADC_BITS)'(aq_s1);
			side_s3 <= side_s2;
			x_s3    <= SQ_IN_W'({isq_s2 + qsq_s2, 4'b0000});
		end
	end

	// square root
	logic             sq_v;
	logic [MAG_W-1:0] sq_root;
	side_t            sq_side;
	side_t            sq_side_m;

	biq_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_x      (x_s3),
		.in_side   (side_s3),
		.out_valid (sq_v),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	always_comb begin
		sq_side_m     = sq_side;
		sq_side_m.mag = sq_root;
	end

	// stage 4: magnitude times the scale numerator
	logic               v_s4;
	side_t              side_s4;
	logic [PROD1_W-1:0] prod_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= sq_side_m;
			prod_s4 <= PROD1_W'(sq_root) * PROD1_W'(SCALE_NUM);
		end
	end

	// divider by the drive current, one quotient bit per stage
	logic             d1_v_s    [N1_W];
	logic [CUR_W-1:0] d1_rem_s  [N1_W];
	logic [N1_W-1:0]  d1_num_s  [N1_W];
	logic [N1_W-1:0]  d1_quo_s  [N1_W];
	side_t            d1_side_s [N1_W];

	for (genvar g = 0; g < N1_W; g++) begin : g_div1
		logic             pv;
		logic [CUR_W-1:0] prem;
		logic [N1_W-1:0]  pnum;
		logic [N1_W-1:0]  pquo;
		side_t            pside;
		logic [CUR_W:0]   cur;
		logic             take;

		if (g == 0) begin : g_first
			assign pv    = v_s4;
			assign prem  = '0;
			assign pnum  = prod_s4[PROD1_W-1:SCALE_SHIFT];
			assign pquo  = '0;
			assign pside = side_s4;
		end else begin : g_next
			assign pv    = d1_v_s[g-1];
			assign prem  = d1_rem_s[g-1];
			assign pnum  = d1_num_s[g-1];
			assign pquo  = d1_quo_s[g-1];
			assign pside = d1_side_s[g-1];
		end

		always_comb begin
			cur  = {prem, pnum[N1_W-1]};
			take = (cur >= {1'b0, drive_q});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d1_v_s[g] <= 1'b0;
			end else if (en) begin
				d1_v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d1_rem_s[g]  <= take ? CUR_W'(cur - {1'b0, drive_q}) : cur[CUR_W-1:0];
				d1_num_s[g]  <= {pnum[N1_W-2:0], 1'b0};
				d1_quo_s[g]  <= {pquo[N1_W-2:0], take};
				d1_side_s[g] <= pside;
			end
		end
	end

	// stage 5: saturate the impedance
	logic            v_s5;
	side_t           side_s5;
	logic [Z_W-1:0]  z_s5;
	logic            ovf_s5;
	logic [N1_W-1:0] q1;

	assign q1 = d1_quo_s[N1_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= d1_v_s[N1_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= d1_side_s[N1_W-1];
			if (drive_q == '0 || q1[N1_W-1:Z_W] != '0) begin
				z_s5   <= Z_SAT;
				ovf_s5 <= 1'b1;
			end else begin
				z_s5   <= q1[Z_W-1:0];
				ovf_s5 <= 1'b0;
			end
		end
	end

	// stage 6: z*R, 16R-z and the leakage limit check
	logic               v_s6;
	side_t              side_s6;
	logic [Z_W-1:0]     z_s6;
	logic               ovf_s6;
	logic [PROD2_W-1:0] prod2_s6;
	logic               ge_s6;
	logic [DEN_W-1:0]   den_s6;
	logic [DEN_W-1:0]   r16;

	assign r16 = {leak_q, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s6  <= side_s5;
			z_s6     <= z_s5;
			ovf_s6   <= ovf_s5;
			prod2_s6 <= PROD2_W'(z_s5) * PROD2_W'(leak_q);
			ge_s6    <= (z_s5 >= Z_W'(r16));
			den_s6   <= r16 - z_s5[DEN_W-1:0];
		end
	end

	// stage 7: a quotient of 2^34 or more saturates anyway
	logic             v_s7;
	side_t            side_s7;
	logic [Z_W-1:0]   z_s7;
	logic             ovf_s7;
	logic             sat_s7;
	logic [DEN_W-1:0] den_s7;
	logic [DEN_W-1:0] rem0_s7;
	logic [Q2_W-1:0]  num_s7;
	logic [N2_W-1:0]  num2;

	assign num2 = {prod2_s6, 4'b0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= side_s6;
			z_s7    <= z_s6;
			ovf_s7  <= ovf_s6;
			sat_s7  <= ge_s6 || (DEN_W'(num2[N2_W-1:Q2_W]) >= den_s6);
			den_s7  <= den_s6;
			rem0_s7 <= DEN_W'(num2[N2_W-1:Q2_W]);
			num_s7  <= num2[Q2_W-1:0];
		end
	end

	// divider by 16R-z, one quotient bit per stage
	logic             d2_v_s    [Q2_W];
	logic [DEN_W-1:0] d2_rem_s  [Q2_W];
	logic [DEN_W-1:0] d2_den_s  [Q2_W];
	logic [Q2_W-1:0]  d2_num_s  [Q2_W];
	logic [Q2_W-1:0]  d2_quo_s  [Q2_W];
	logic [Z_W-1:0]   d2_z_s    [Q2_W];
	logic             d2_ovf_s  [Q2_W];
	logic             d2_sat_s  [Q2_W];
	side_t            d2_side_s [Q2_W];

	for (genvar g = 0; g < Q2_W; g++) begin : g_div2
		logic             pv;
		logic [DEN_W-1:0] prem;
		logic [DEN_W-1:0] pden;
		logic [Q2_W-1:0]  pnum;
		logic [Q2_W-1:0]  pquo;
		logic [Z_W-1:0]   pz;
		logic             povf;
		logic             psat;
		side_t            pside;
		logic [DEN_W:0]   cur;
		logic             take;

		if (g == 0) begin : g_first
			assign pv    = v_s7;
			assign prem  = rem0_s7;
			assign pden  = den_s7;
			assign pnum  = num_s7;
			assign pquo  = '0;
			assign pz    = z_s7;
			assign povf  = ovf_s7;
			assign psat  = sat_s7;
			assign pside = side_s7;
		end else begin : g_next
			assign pv    = d2_v_s[g-1];
			assign prem  = d2_rem_s[g-1];
			assign pden  = d2_den_s[g-1];
			assign pnum  = d2_num_s[g-1];
			assign pquo  = d2_quo_s[g-1];
			assign pz    = d2_z_s[g-1];
			assign povf  = d2_ovf_s[g-1];
			assign psat  = d2_sat_s[g-1];
			assign pside = d2_side_s[g-1];
		end

		always_comb begin
			cur  = {prem, pnum[Q2_W-1]};
			take = (cur >= {1'b0, pden});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				d2_v_s[g] <= 1'b0;
			end else if (en) begin
				d2_v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d2_rem_s[g]  <= take ? DEN_W'(cur - {1'b0, pden}) : cur[DEN_W-1:0];
				d2_den_s[g]  <= pden;
				d2_num_s[g]  <= {pnum[Q2_W-2:0], 1'b0};
				d2_quo_s[g]  <= {pquo[Q2_W-2:0], take};
				d2_z_s[g]    <= pz;
				d2_ovf_s[g]  <= povf;
				d2_sat_s[g]  <= psat;
				d2_side_s[g] <= pside;
			end
		end
	end

	// output stage: isolation offset, clamp, zero non-valid items
	side_t             f_side;
	logic [Q2_W-1:0]   f_quo;
	logic [Q2_W-1:0]   f_iso16;
	logic [BODY_W-1:0] f_body;
	logic              f_ovf;
	logic [127:0]      f_data;

	always_comb begin
		f_side  = d2_side_s[Q2_W-1];
		f_quo   = d2_quo_s[Q2_W-1];
		f_iso16 = Q2_W'({iso_q, 4'b0000});
		f_ovf   = d2_ovf_s[Q2_W-1];
		if (d2_sat_s[Q2_W-1] || f_quo > (Q2_W'(Z_SAT) + f_iso16)) begin
			f_body = BODY_W'(Z_SAT);
			f_ovf  = 1'b1;
		end else begin
			f_body = BODY_W'(f_quo - f_iso16);
		end
		f_data = {f_ovf, f_body, d2_z_s[Q2_W-1], f_side.mag,
			f_side.quadrature, f_side.in_phase};
		if (f_side.status != ST_VALID) begin
			f_data = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= d2_v_s[Q2_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_status_q <= f_side.status;
			out_data_q   <= f_data;
		end
	end

	`BIQ_ASSERT_IMPL(a_nonvalid_zero, out_v_q && out_status_q != ST_VALID, out_data_q == '0)
	`BIQ_ASSERT_IMPL(a_sat_flags_ovf, out_v_q && out_status_q == ST_VALID && out_data_q[93:62] == Z_SAT, out_data_q[127])
	`BIQ_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v_s1)
	`BIQ_ASSERT_NEXT(a_stall_holds, !en, $stable(v_s7) && $stable(out_data_q))
	`BIQ_ASSERT_ALWAYS(a_ready_follows_out, s_tready == (!out_v_q || m_tready))
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the I/Q to impedance converter
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import biq_pkg::*;

	// one expected or observed result item
	typedef struct {
		status_t          status;
		logic [19:0]      in_phase;
		logic [19:0]      quadrature;
		logic [21:0]      mag;
		logic [31:0]      imp;
		logic [32:0]      body;
		logic             ovf;
	} imp_result_t;

	// impedance predictor and store of pending results
	class imp_scoreboard;
		longint unsigned cur_na, leak_ohm, iso_ohm;
		imp_result_t pending[$];
		int errors, n_checked, n_valid, n_ovf;

		function new();
			cur_na = CUR_RST;
			leak_ohm = LEAK_RST;
			iso_ohm = ISO_RST;
			errors = 0;
			n_checked = 0;
			n_valid = 0;
			n_ovf = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			if (idx == CFG_DRIVE) cur_na = val[15:0];
			else if (idx == CFG_LEAK) leak_ohm = val;
			else if (idx == CFG_ISO) iso_ohm = val[15:0];
		endfunction

		// bitwise integer square root, floored
		function longint unsigned int_sqrt(longint unsigned x);
			longint unsigned root, bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= root + bitv) begin
					x -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		function void note_input(logic [23:0] wa, logic [23:0] wb);
			imp_result_t r;
			logic [23:0] iw, qw;
			logic signed [19:0] si, sq;
			longint signed ii, qq;
			longint unsigned m, z, body, r16, iso16, quo;
			bit ov;
			r = '{ST_TAG_ERR, '0, '0, '0, '0, '0, 1'b0};
			if (wa[23:20] == TAG_I && wb[23:20] == TAG_Q) begin
				iw = wa; qw = wb; r.status = ST_VALID;
			end else if (wa[23:20] == TAG_Q && wb[23:20] == TAG_I) begin
				iw = wb; qw = wa; r.status = ST_VALID;
			end else if (wa == WORD_INVALID && wb == WORD_INVALID) begin
				r.status = ST_INVALID;
			end else if (wa == WORD_MARKER && wb == WORD_INVALID) begin
				r.status = ST_MARKER;
			end
			if (r.status == ST_VALID) begin
				si = iw[19:0];
				sq = qw[19:0];
				ii = si;
				qq = sq;
				m = int_sqrt(16 * (ii * ii + qq * qq));
				ov = 0;
				if (cur_na == 0) begin
					z = 64'hFFFFFFFF; ov = 1;
				end else begin
					z = (m * 64'd3140000000) / (64'd262144 * cur_na);
					if (z > 64'hFFFFFFFF) begin
						z = 64'hFFFFFFFF; ov = 1;
					end
				end
				r16 = 16 * leak_ohm;
				iso16 = 16 * iso_ohm;
				if (z >= r16) begin
					body = 64'hFFFFFFFF; ov = 1;
				end else begin
					quo = (16 * z * leak_ohm) / (r16 - z);
					if (quo > 64'hFFFFFFFF + iso16) begin
						body = 64'hFFFFFFFF; ov = 1;
					end else begin
						body = quo - iso16;
					end
				end
				r.in_phase = si;
				r.quadrature = sq;
				r.mag = m[21:0];
				r.imp = z[31:0];
				r.body = body[32:0];
				r.ovf = ov;
			end
			pending.push_back(r);
		endfunction

		function void check(logic [127:0] d, logic [1:0] u);
			imp_result_t e;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: tuser=%0d tdata=%h", u, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			n_checked++;
			if (e.status == ST_VALID) n_valid++;
			if (e.ovf) n_ovf++;
			if (u !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, u); errors++;
			end
			if (d[19:0] !== e.in_phase) begin
				$error("in_phase: expected %h, got %h", e.in_phase, d[19:0]); errors++;
			end
			if (d[39:20] !== e.quadrature) begin
				$error("quadrature: expected %h, got %h", e.quadrature, d[39:20]);
				errors++;
			end
			if (d[61:40] !== e.mag) begin
				$error("magnitude_q2: expected %0d, got %0d", e.mag, d[61:40]); errors++;
			end
			if (d[93:62] !== e.imp) begin
				$error("impedance_q4: expected %0d, got %0d", e.imp, d[93:62]); errors++;
			end
			if (d[126:94] !== e.body) begin
				$error("body_impedance_q4: expected %h, got %h", e.body, d[126:94]);
				errors++;
			end
			if (d[127] !== e.ovf) begin
				$error("overflow: expected %0d, got %0d", e.ovf, d[127]); errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [47:0]   s_tdata;  // word_a [23:0], word_b [47:24]
	logic          m_tvalid;
	logic          m_tready;
	// in_phase [19:0], quadrature [39:20], magnitude_q2 [61:40],
	// impedance_q4 [93:62], body_impedance_q4 [126:94], overflow [127]
	logic [127:0]  m_tdata;
	logic [1:0]    m_tuser;  // status [1:0]
	logic          cfg_we;
	logic [1:0]    cfg_index;
	logic [23:0]   cfg_data;

	imp_scoreboard sb = new();
	int burst_left;
	int stall_mode;

	bioimpedance_iq_to_impedance DUT (.*);

	// clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// run limit
	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	// input and output monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) sb.note_input(s_tdata[23:0], s_tdata[47:24]);
		if (arst_n && m_tvalid && m_tready) sb.check(m_tdata, m_tuser);
	end

	// receiver stall pattern, mode changed by the stimulus
	always @(posedge clk) begin
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			2: m_tready <= ($urandom_range(0, 9) < 2);
			default: m_tready <= ($urandom_range(0, 31) != 0);
		endcase
	end

	// send one item, gaps between random bursts
	task automatic send_item(logic [23:0] wa, logic [23:0] wb);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {wb, wa};
		@(posedge clk iff (s_tvalid && s_tready));
		burst_left--;
	endtask

	// drain the pipeline, then write the three registers
	task automatic set_regs(logic [23:0] cur, logic [23:0] leak, logic [23:0] iso);
		logic [23:0] vals[3];
		logic [1:0] idx[3];
		vals = '{cur, leak, iso};
		idx = '{CFG_DRIVE, CFG_LEAK, CFG_ISO};
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (110) @(posedge clk);
		for (int k = 0; k < 3; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= vals[k];
			@(posedge clk);
			sb.set_reg(idx[k], vals[k]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random item: mostly tagged pairs, the rest noise and framing words
	task automatic random_item();
		logic [23:0] a, b;
		int pick;
		pick = $urandom_range(0, 99);
		a = 24'($urandom);
		b = 24'($urandom);
		if (pick < 80) begin
			a[23:20] = TAG_I;
			b[23:20] = TAG_Q;
			if ($urandom_range(0, 1)) send_item(b, a);
			else send_item(a, b);
		end else if (pick < 84) begin
			send_item(WORD_INVALID, WORD_INVALID);
		end else if (pick < 88) begin
			send_item(WORD_MARKER, WORD_INVALID);
		end else begin
			send_item(a, b);
		end
	endtask

	initial begin
		logic [23:0] cur_v, leak_v, iso_v;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_DRIVE;
		cfg_data = '0;
		stall_mode = 0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: sample extremes, both tag orders, framing words
		send_item(24'h17FFFF, 24'h280000);
		send_item(24'h280000, 24'h17FFFF);
		send_item(24'h180000, 24'h27FFFF);
		send_item(24'h100000, 24'h200000);
		send_item(24'h1FFFFF, 24'h2FFFFF);
		send_item(24'h200001, 24'h100001);
		send_item(WORD_INVALID, WORD_INVALID);
		send_item(WORD_MARKER, WORD_INVALID);
		send_item(WORD_INVALID, WORD_MARKER);
		send_item(24'h100000, 24'h100000);
		send_item(24'h000000, 24'h000000);
		send_item(24'hF7FFFF, 24'h2FFFFF);
		send_item(24'h1ABCDE, 24'h354321);
		send_item(24'hC12345, 24'h300000);

		// configuration phases: defaults, extremes, then random
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					cur_v = 24'(CUR_RST); leak_v = LEAK_RST; iso_v = 24'(ISO_RST);
				end
				1: begin cur_v = 24'd1; leak_v = 24'hFFFFFF; iso_v = 24'hFFFF; end
				2: begin cur_v = 24'hFFFF; leak_v = 24'd1; iso_v = '0; end
				3: begin cur_v = 24'hFFFF; leak_v = 24'hFFFFFF; iso_v = 24'hFFFF; end
				4: begin cur_v = '0; leak_v = '0; iso_v = '0; end
				default: begin
					cur_v = 24'($urandom_range(1, 65535));
					leak_v = 24'($urandom_range(1, 24'hFFFFFF));
					iso_v = 24'($urandom_range(0, 65535));
				end
			endcase
			set_regs(cur_v, leak_v, iso_v);
			stall_mode = ph % 4;
			send_item(24'h17FFFF, 24'h280000);
			send_item(24'h280000, 24'h27FFFF);
			for (int n = 0; n < 175; n++) begin
				if (n % 50 == 0) stall_mode = $urandom_range(0, 3);
				random_item();
			end
		end

		// drain
		s_tvalid <= 1'b0;
		stall_mode = 1;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (110) @(posedge clk);
		$display("Checked %0d results (%0d valid samples, %0d overflows) over 7 register",
			sb.n_checked, sb.n_valid, sb.n_ovf);
		$display("settings including zero current, zero and full-scale leakage resistance.");
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
